### rtl/core/differential_evolution_step_unit_macros.svh
// Assertion helpers for the differential evolution step unit.
`ifndef DIFFERENTIAL_EVOLUTION_STEP_UNIT_MACROS_SVH
`define DIFFERENTIAL_EVOLUTION_STEP_UNIT_MACROS_SVH

// Clocked assertion that is held off while reset is asserted (active low).
`define DES_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define DES_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/des_pkg.sv
package des_pkg;

    // Population limits.
    localparam int POP_MAX = 64;
    localparam int IND_MAX = 256;

    // Field widths of one input beat and one result beat.
    localparam int FUNC_W  = 3;
    localparam int IDX_W   = 6;
    localparam int EL_W    = 8;
    localparam int VAL_W   = 16;
    localparam int DRAW_W  = 16;
    localparam int COST_W  = 32;

    // Population memory geometry: address is {individual, element}.
    localparam int MEM_AW    = IDX_W + EL_W;
    localparam int MEM_DEPTH = POP_MAX * IND_MAX;
    localparam int COST_AW   = $clog2(POP_MAX);

    // Configuration registers.
    localparam int POP_CFG_W  = 7;
    localparam int IND_CFG_W  = 9;
    localparam int F_W        = 13;
    localparam int CR_W       = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_POP_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IND_SIZE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_WEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CROSS_RATE  = 2'd3;

    localparam logic [POP_CFG_W-1:0] POP_SIZE_RST    = 7'd64;
    localparam logic [IND_CFG_W-1:0] IND_SIZE_RST    = 9'd256;
    localparam logic [F_W-1:0]       DIFF_WEIGHT_RST = 13'd2458;
    localparam logic [CR_W-1:0]      CROSS_RATE_RST  = 16'd26214;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_TRIAL = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_OFFER = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd4;

    // Population read address selection.
    localparam logic [1:0] RD_TGT = 2'd0;
    localparam logic [1:0] RD_LO  = 2'd1;
    localparam logic [1:0] RD_MID = 2'd2;
    localparam logic [1:0] RD_HI  = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [IDX_W-1:0]         individual;
        logic [EL_W-1:0]          element;
        logic signed [VAL_W-1:0]  value;
        logic [IDX_W-1:0]         pick_one;
        logic [IDX_W-1:0]         pick_two;
        logic [IDX_W-1:0]         pick_three;
        logic [DRAW_W-1:0]        cross_draw;
        logic [EL_W-1:0]          forced_element;
        logic signed [COST_W-1:0] cost;
    } t_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_value;
        logic                    accepted;
        logic [IDX_W-1:0]        best_individual;
        logic                    error;
    } t_result;

    // Controller to datapath commands.
    typedef struct packed {
        logic       load_item;
        logic       cur_wr_load;
        logic       set_cost;
        logic [1:0] rd_sel;
        logic       cap_en;
        logic [1:0] cap_sel;
        logic       mul;
        logic       res_trial;
        logic       res_read;
        logic       offer_acc;
        logic       copy_start;
        logic       copy_step;
        logic       out_load;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic              err;
        logic [FUNC_W-1:0] func;
        logic              offer_win;
        logic              copy_done;
    } t_sts;

endpackage

### rtl/core/des_item_if.sv
interface des_item_if;
    logic           valid;
    logic           ready;
    des_pkg::t_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/des_res_if.sv
interface des_res_if;
    logic             valid;
    logic             ready;
    des_pkg::t_result payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/des_ram.sv
module des_ram #(
    parameter int W = 16,
    parameter int D = 16384
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/core/des_ctrl.sv
`include "differential_evolution_step_unit_macros.svh"

module des_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  des_pkg::t_sts i_sts,
    output des_pkg::t_cmd o_cmd
);
    import des_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_T0, S_T1, S_T2, S_T3, S_T4, S_MUL, S_SUM,
        S_RD0, S_RD1, S_CMP, S_COPY, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.err) begin
                    n_state = S_DONE;
                end else begin
                    case (i_sts.func)
                        FUNC_LOAD: begin
                            o_cmd.cur_wr_load = 1'b1;
                            n_state           = S_DONE;
                        end
                        FUNC_SET: begin
                            o_cmd.set_cost = 1'b1;
                            n_state        = S_DONE;
                        end
                        FUNC_TRIAL: n_state = S_T0;
                        FUNC_OFFER: n_state = S_CMP;
                        FUNC_READ:  n_state = S_RD0;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_T0: begin
                o_cmd.rd_sel = RD_TGT;
                n_state      = S_T1;
            end
            S_T1: begin
                o_cmd.rd_sel  = RD_LO;
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = RD_TGT;
                n_state       = S_T2;
            end
            S_T2: begin
                o_cmd.rd_sel  = RD_MID;
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = RD_LO;
                n_state       = S_T3;
            end
            S_T3: begin
                o_cmd.rd_sel  = RD_HI;
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = RD_MID;
                n_state       = S_T4;
            end
            S_T4: begin
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = RD_HI;
                n_state       = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.res_trial = 1'b1;
                n_state         = S_DONE;
            end
            S_RD0: begin
                o_cmd.rd_sel = RD_TGT;
                n_state      = S_RD1;
            end
            S_RD1: begin
                o_cmd.res_read = 1'b1;
                n_state        = S_DONE;
            end
            S_CMP: begin
                if (i_sts.offer_win) begin
                    o_cmd.offer_acc  = 1'b1;
                    o_cmd.copy_start = 1'b1;
                    n_state          = S_COPY;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_COPY: begin
                if (i_sts.copy_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.copy_step = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output beat valid: set when a result is loaded, cleared when taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `DES_ASSERT(a_fire_to_check, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> (r_state == S_CHECK), "accepted beat did not enter decode")
    `DES_ASSERT(a_no_overwrite, i_clk, i_rst_n, o_cmd.out_load |-> (!r_out_valid || i_out_ready), "result loaded over a waiting beat")
    `DES_ASSERT(a_copy_clean, i_clk, i_rst_n, (r_state == S_COPY) |-> (!i_sts.err && (i_sts.func == FUNC_OFFER)), "copy running for a faulty or foreign item")
endmodule

### rtl/core/des_dpath.sv
module des_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [des_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [des_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  des_pkg::t_item                 i_item,
    input  des_pkg::t_cmd                  i_cmd,
    output des_pkg::t_sts                  o_sts,
    output des_pkg::t_result               o_result
);
    import des_pkg::*;

    // Configuration registers.
    logic [POP_CFG_W-1:0] r_pop_size;
    logic [IND_CFG_W-1:0] r_ind_size;
    logic [F_W-1:0]       r_diff_weight;
    logic [CR_W-1:0]      r_cross_rate;

    t_item r_item;

    logic [POP_CFG_W-1:0] w_pop_use;
    logic [IND_CFG_W-1:0] w_isz;

    logic [IDX_W-1:0] w_s0, w_s1, w_s2, w_s3, w_lo, w_mid, w_hi;
    logic             w_ind_ok, w_el_ok, w_frc_ok, w_pk_ok, w_dist, w_err;

    logic [MEM_AW-1:0]   w_cur_raddr, w_cur_waddr, w_nxt_raddr;
    logic                w_cur_we;
    logic [VAL_W-1:0]    w_cur_wdata, w_cur_rdata, w_nxt_rdata;
    logic [COST_W-1:0]   w_cost_rdata;
    logic                w_cost_we;

    logic [POP_MAX-1:0]  r_cost_vld;
    logic                r_cost_rvld;
    logic signed [COST_W-1:0] w_cur_cost;

    logic [IDX_W-1:0]         r_best;
    logic signed [COST_W-1:0] r_best_cost;

    logic signed [VAL_W-1:0] r_tgt, r_base, r_mid, r_hi;
    logic signed [VAL_W:0]   w_diff;
    logic signed [30:0]      r_prod;
    logic signed [31:0]      w_p;
    logic signed [19:0]      w_scaled;
    logic signed [20:0]      w_sum;
    logic signed [VAL_W-1:0] w_mut, w_trial;
    logic                    w_keep;

    logic signed [VAL_W-1:0] r_res_value;
    logic                    r_accepted;
    t_result                 r_out;

    logic [IND_CFG_W-1:0] r_cnt;
    logic                 r_wr_pend;
    logic [EL_W-1:0]      r_wr_el;

    // Clamp the sizes in use to the storage limits.
    assign w_pop_use = (r_pop_size > POP_CFG_W'(POP_MAX)) ? POP_CFG_W'(POP_MAX) : r_pop_size;
    assign w_isz     = (r_ind_size > IND_CFG_W'(IND_MAX)) ? IND_CFG_W'(IND_MAX) : r_ind_size;

    // Sort the three picks ascending with three compare-swaps.
    always_comb begin
        w_s0 = (r_item.pick_one > r_item.pick_two) ? r_item.pick_two : r_item.pick_one;
        w_s1 = (r_item.pick_one > r_item.pick_two) ? r_item.pick_one : r_item.pick_two;
        w_s2 = (w_s1 > r_item.pick_three) ? r_item.pick_three : w_s1;
        w_hi = (w_s1 > r_item.pick_three) ? w_s1 : r_item.pick_three;
        w_s3 = (w_s0 > w_s2) ? w_s2 : w_s0;
        w_lo = w_s3;
        w_mid = (w_s0 > w_s2) ? w_s0 : w_s2;
    end

    // Range and distinctness checks on the held item.
    always_comb begin
        w_ind_ok = {1'b0, r_item.individual} < w_pop_use;
        w_el_ok  = {1'b0, r_item.element} < w_isz;
        w_frc_ok = {1'b0, r_item.forced_element} < w_isz;
        w_pk_ok  = ({1'b0, r_item.pick_one} < w_pop_use) &&
                   ({1'b0, r_item.pick_two} < w_pop_use) &&
                   ({1'b0, r_item.pick_three} < w_pop_use);
        w_dist   = (r_item.pick_one != r_item.pick_two) &&
                   (r_item.pick_one != r_item.pick_three) &&
                   (r_item.pick_two != r_item.pick_three) &&
                   (r_item.pick_one != r_item.individual) &&
                   (r_item.pick_two != r_item.individual) &&
                   (r_item.pick_three != r_item.individual);
        case (r_item.func)
            FUNC_LOAD, FUNC_READ: w_err = !(w_ind_ok && w_el_ok);
            FUNC_SET, FUNC_OFFER: w_err = !w_ind_ok;
            FUNC_TRIAL: w_err = !(w_ind_ok && w_el_ok && w_frc_ok && w_pk_ok && w_dist);
            default:    w_err = 1'b1;
        endcase
    end

    // Population address selection.
    always_comb begin
        case (i_cmd.rd_sel)
            RD_TGT:  w_cur_raddr = {r_item.individual, r_item.element};
            RD_LO:   w_cur_raddr = {w_lo, r_item.element};
            RD_MID:  w_cur_raddr = {w_mid, r_item.element};
            default: w_cur_raddr = {w_hi, r_item.element};
        endcase
        w_cur_we    = i_cmd.cur_wr_load || r_wr_pend;
        w_cur_waddr = i_cmd.cur_wr_load ? {r_item.individual, r_item.element}
                                        : {r_item.individual, r_wr_el};
        w_cur_wdata = i_cmd.cur_wr_load ? r_item.value : w_nxt_rdata;
        w_nxt_raddr = {r_item.individual, r_cnt[EL_W-1:0]};
    end

    des_ram #(.W(VAL_W), .D(MEM_DEPTH)) u_cur_ram (
        .i_clk   (i_clk),
        .i_we    (w_cur_we),
        .i_waddr (w_cur_waddr),
        .i_wdata (w_cur_wdata),
        .i_raddr (w_cur_raddr),
        .o_rdata (w_cur_rdata)
    );

    des_ram #(.W(VAL_W), .D(MEM_DEPTH)) u_nxt_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.res_trial),
        .i_waddr ({r_item.individual, r_item.element}),
        .i_wdata (w_trial),
        .i_raddr (w_nxt_raddr),
        .o_rdata (w_nxt_rdata)
    );

    // Cost table: memory plus one valid bit per entry; unwritten reads as zero.
    assign w_cost_we = i_cmd.set_cost || i_cmd.offer_acc;

    des_ram #(.W(COST_W), .D(POP_MAX)) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (w_cost_we),
        .i_waddr (r_item.individual[COST_AW-1:0]),
        .i_wdata (r_item.cost),
        .i_raddr (r_item.individual[COST_AW-1:0]),
        .o_rdata (w_cost_rdata)
    );

    assign w_cur_cost = r_cost_rvld ? $signed(w_cost_rdata) : '0;

    // Mutant: base + round(F * (mid - hi)), saturated.
    always_comb begin
        w_diff   = {r_mid[VAL_W-1], r_mid} - {r_hi[VAL_W-1], r_hi};
        w_p      = {r_prod[30], r_prod} + 32'sd2048;
        w_scaled = w_p[31:12];
        w_sum    = {{5{r_base[VAL_W-1]}}, r_base} + {w_scaled[19], w_scaled};
        if (w_sum > 21'sd32767) begin
            w_mut = 16'sh7FFF;
        end else if (w_sum < -21'sd32768) begin
            w_mut = -16'sh8000;
        end else begin
            w_mut = w_sum[VAL_W-1:0];
        end
        w_keep  = (r_item.element != r_item.forced_element) &&
                  (r_item.cross_draw >= r_cross_rate);
        w_trial = w_keep ? r_tgt : w_mut;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pop_size    <= POP_SIZE_RST;
            r_ind_size    <= IND_SIZE_RST;
            r_diff_weight <= DIFF_WEIGHT_RST;
            r_cross_rate  <= CROSS_RATE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POP_SIZE:    r_pop_size    <= i_cfg_data[POP_CFG_W-1:0];
                CFG_IND_SIZE:    r_ind_size    <= i_cfg_data[IND_CFG_W-1:0];
                CFG_DIFF_WEIGHT: r_diff_weight <= i_cfg_data[F_W-1:0];
                CFG_CROSS_RATE:  r_cross_rate  <= i_cfg_data[CR_W-1:0];
                default: ;
            endcase
        end
    end

    // Control state: cost valid bits, best individual, copy sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cost_vld  <= '0;
            r_cost_rvld <= 1'b0;
            r_best      <= '0;
            r_best_cost <= '0;
            r_cnt       <= '0;
            r_wr_pend   <= 1'b0;
        end else begin
            r_cost_rvld <= r_cost_vld[r_item.individual[COST_AW-1:0]];
            if (w_cost_we) begin
                r_cost_vld[r_item.individual[COST_AW-1:0]] <= 1'b1;
            end
            // Re-setting the best entry only moves its cost.
            if (i_cmd.set_cost) begin
                if (r_item.individual == r_best) begin
                    r_best_cost <= r_item.cost;
                end else if (r_item.cost < r_best_cost) begin
                    r_best      <= r_item.individual;
                    r_best_cost <= r_item.cost;
                end
            end
            if (i_cmd.offer_acc && (r_item.individual == r_best)) begin
                r_best_cost <= r_item.cost;
            end
            // Copy: read an element of the next population, write it into the current one in the cycle after.
            if (i_cmd.copy_start) begin
                r_cnt     <= '0;
                r_wr_pend <= 1'b0;
            end else if (i_cmd.copy_step) begin
                if (r_cnt < w_isz) begin
                    r_cnt     <= r_cnt + 1'b1;
                    r_wr_pend <= 1'b1;
                end else begin
                    r_wr_pend <= 1'b0;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_wr_el <= r_cnt[EL_W-1:0];
        if (i_cmd.load_item) begin
            r_item      <= i_item;
            r_res_value <= '0;
            r_accepted  <= 1'b0;
        end
        if (i_cmd.cap_en) begin
            case (i_cmd.cap_sel)
                RD_TGT:  r_tgt  <= w_cur_rdata;
                RD_LO:   r_base <= w_cur_rdata;
                RD_MID:  r_mid  <= w_cur_rdata;
                default: r_hi   <= w_cur_rdata;
            endcase
        end
        if (i_cmd.mul) begin
            r_prod <= w_diff * $signed({1'b0, r_diff_weight});
        end
        if (i_cmd.res_trial) begin
            r_res_value <= w_trial;
        end
        if (i_cmd.res_read) begin
            r_res_value <= w_cur_rdata;
        end
        if (i_cmd.offer_acc) begin
            r_accepted <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out.result_value    <= r_res_value;
            r_out.accepted        <= r_accepted;
            r_out.best_individual <= r_best;
            r_out.error           <= w_err;
        end
    end

    assign o_sts.err       = w_err;
    assign o_sts.func      = r_item.func;
    assign o_sts.offer_win = r_item.cost < w_cur_cost;
    assign o_sts.copy_done = (r_cnt == w_isz) && !r_wr_pend;
    assign o_result        = r_out;
endmodule

### rtl/core/differential_evolution_step_unit.sv
// A trial element makes four reads through the single population read port, then runs one
// multiply stage and one add and saturate stage. An offer is either rejected or copies the
// vector, one element per cycle; the next beat is taken in the cycle after the result loads,
// so one item at a time.
// Reset is synchronous, active low: configuration registers return to their defaults,
// costs read as zero.
module differential_evolution_step_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    des_item_if.sink                       i_item,
    des_res_if.source                      o_result,
    input  logic                           i_cfg_we,
    input  logic [des_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [des_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import des_pkg::*;

    t_cmd    w_cmd;
    t_sts    w_sts;
    t_result w_res;
    logic    w_in_ready, w_out_valid;

    // Sequencer.
    des_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_result.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Storage and arithmetic.
    des_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item.payload),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_result   (w_res)
    );

    assign i_item.ready     = w_in_ready;
    assign o_result.valid   = w_out_valid;
    assign o_result.payload = w_res;
endmodule

### tb/des_result_checker.sv
module des_result_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    des_item_if                            item_bus,
    des_res_if                             res_bus,
    input  logic                           i_cfg_we,
    input  logic [des_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [des_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_accept_count
);
    import des_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the block state and its registers.
    logic [VAL_W-1:0]         cur_mem [MEM_DEPTH];
    logic [VAL_W-1:0]         nxt_mem [MEM_DEPTH];
    logic signed [COST_W-1:0] cost_tab [POP_MAX];
    logic [IDX_W-1:0]         best_idx;
    logic [POP_CFG_W-1:0]     pop_reg;
    logic [IND_CFG_W-1:0]     ind_reg;
    logic [F_W-1:0]           weight_reg;
    logic [CR_W-1:0]          rate_reg;
    t_result                  expected_results [$];

    initial begin
        for (int k = 0; k < MEM_DEPTH; k++) begin
            cur_mem[k] = '0;
            nxt_mem[k] = '0;
        end
    end

    // Mutant element: base plus the weighted difference, rounded and saturated.
    function automatic logic [VAL_W-1:0] mutate(input logic [VAL_W-1:0] base,
                                                input logic [VAL_W-1:0] mid,
                                                input logic [VAL_W-1:0] hi);
        longint d;
        longint p;
        longint s;
        d = longint'($signed(mid)) - longint'($signed(hi));
        p = d * longint'(weight_reg) + 2048;
        s = longint'($signed(base)) + (p >>> 12);
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        return s[VAL_W-1:0];
    endfunction

    // Apply one item to the shadow state and return what the block must answer.
    function automatic t_result apply_item(input t_item it);
        t_result r;
        int      pop_u;
        int      ind_u;
        int      lo;
        int      mid;
        int      hi;
        int      t;
        logic    ind_ok;
        logic    el_ok;
        r = '0;
        pop_u = (pop_reg < POP_MAX) ? int'(pop_reg) : POP_MAX;
        ind_u = (ind_reg < IND_MAX) ? int'(ind_reg) : IND_MAX;
        ind_ok = int'(it.individual) < pop_u;
        el_ok  = int'(it.element) < ind_u;
        case (it.func)
            FUNC_LOAD: begin
                if (ind_ok && el_ok) cur_mem[{it.individual, it.element}] = it.value;
                else r.error = 1'b1;
            end
            FUNC_SET: begin
                if (ind_ok) begin
                    cost_tab[it.individual] = it.cost;
                    if (it.cost < cost_tab[best_idx]) best_idx = it.individual;
                end else begin
                    r.error = 1'b1;
                end
            end
            FUNC_TRIAL: begin
                lo = it.pick_one;
                mid = it.pick_two;
                hi = it.pick_three;
                if (!ind_ok || !el_ok || int'(it.forced_element) >= ind_u ||
                    lo >= pop_u || mid >= pop_u || hi >= pop_u ||
                    lo == mid || lo == hi || mid == hi ||
                    lo == it.individual || mid == it.individual || hi == it.individual) begin
                    r.error = 1'b1;
                end else begin
                    if (lo > mid) begin t = lo; lo = mid; mid = t; end
                    if (mid > hi) begin t = mid; mid = hi; hi = t; end
                    if (lo > mid) begin t = lo; lo = mid; mid = t; end
                    if (it.element != it.forced_element && it.cross_draw >= rate_reg)
                        r.result_value = cur_mem[{it.individual, it.element}];
                    else
                        r.result_value = mutate(cur_mem[{lo[IDX_W-1:0], it.element}],
                                                cur_mem[{mid[IDX_W-1:0], it.element}],
                                                cur_mem[{hi[IDX_W-1:0], it.element}]);
                    nxt_mem[{it.individual, it.element}] = r.result_value;
                end
            end
            FUNC_OFFER: begin
                if (ind_ok) begin
                    if (it.cost < cost_tab[it.individual]) begin
                        for (int e = 0; e < ind_u; e++)
                            cur_mem[{it.individual, e[EL_W-1:0]}] =
                                nxt_mem[{it.individual, e[EL_W-1:0]}];
                        cost_tab[it.individual] = it.cost;
                        r.accepted = 1'b1;
                    end
                end else begin
                    r.error = 1'b1;
                end
            end
            FUNC_READ: begin
                if (ind_ok && el_ok) r.result_value = cur_mem[{it.individual, it.element}];
                else r.error = 1'b1;
            end
            default: r.error = 1'b1;
        endcase
        r.best_individual = best_idx;
        return r;
    endfunction

    // Compare result beats first, then predict for a newly accepted item beat.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            for (int k = 0; k < POP_MAX; k++) cost_tab[k] = '0;
            best_idx       = '0;
            pop_reg        = POP_SIZE_RST;
            ind_reg        = IND_SIZE_RST;
            weight_reg     = DIFF_WEIGHT_RST;
            rate_reg       = CROSS_RATE_RST;
            o_fail_count   = 0;
            o_accept_count = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POP_SIZE:    pop_reg    = i_cfg_data[POP_CFG_W-1:0];
                    CFG_IND_SIZE:    ind_reg    = i_cfg_data[IND_CFG_W-1:0];
                    CFG_DIFF_WEIGHT: weight_reg = i_cfg_data[F_W-1:0];
                    CFG_CROSS_RATE:  rate_reg   = i_cfg_data[CR_W-1:0];
                    default: ;
                endcase
            end
            if (res_bus.valid && res_bus.ready) begin
                got = res_bus.payload;
                if (expected_results.size() == 0) begin
                    $error("result beat with no item outstanding");
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.accepted) o_accept_count++;
                    if (got.result_value !== want.result_value) begin
                        $error("result_value: expected %0d, got %0d",
                               want.result_value, got.result_value);
                        o_fail_count++;
                    end
                    if (got.accepted !== want.accepted) begin
                        $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
                        o_fail_count++;
                    end
                    if (got.best_individual !== want.best_individual) begin
                        $error("best_individual: expected %0d, got %0d",
                               want.best_individual, got.best_individual);
                        o_fail_count++;
                    end
                    if (got.error !== want.error) begin
                        $error("error: expected %0d, got %0d", want.error, got.error);
                        o_fail_count++;
                    end
                end
            end
            if (item_bus.valid && item_bus.ready)
                expected_results.push_back(apply_item(item_bus.payload));
        end
        o_pending = expected_results.size();
    end
endmodule

### tb/tb.sv
module tb;
    import des_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1500000;
    localparam int SETTLE_CYCLES = 300;
    localparam int NUM_PHASES   = 9;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    fail_count;
    int                    pending;
    int                    accept_count;
    int                    cycles = 0;
    logic                  quiet;

    des_item_if item_bus ();
    des_res_if  res_bus ();

    differential_evolution_step_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_bus.sink),
        .o_result   (res_bus.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    des_result_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .item_bus       (item_bus),
        .res_bus        (res_bus),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_accept_count (accept_count)
    );

    // Which population entries hold written data, and the sizes in use.
    bit cur_written [MEM_DEPTH];
    bit nxt_written [MEM_DEPTH];
    int pop_u;
    int ind_u;
    int func_count [8];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Cycle counter with a hard ceiling.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int idle_draw();
        return quiet ? 0 : $urandom_range(0, 13);
    endfunction

    // Result receiver: random stall before each beat.
    initial begin
        int gap;
        res_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = idle_draw();
            if (gap > 0) begin
                res_bus.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_bus.valid) @(posedge i_clk);
        end
    end

    function automatic bit trial_ok(input t_item it);
        int a;
        int b;
        int c;
        a = it.pick_one;
        b = it.pick_two;
        c = it.pick_three;
        return it.individual < pop_u && it.element < ind_u && it.forced_element < ind_u &&
               a < pop_u && b < pop_u && c < pop_u && a != b && a != c && b != c &&
               a != it.individual && b != it.individual && c != it.individual;
    endfunction

    function automatic t_item item_of(input logic [FUNC_W-1:0] func, input int ind,
                                      input int el, input int val, input int p1,
                                      input int p2, input int p3, input int draw,
                                      input int forced, input int cost);
        t_item it;
        it.func = func;
        it.individual = ind[IDX_W-1:0];
        it.element = el[EL_W-1:0];
        it.value = val[VAL_W-1:0];
        it.pick_one = p1[IDX_W-1:0];
        it.pick_two = p2[IDX_W-1:0];
        it.pick_three = p3[IDX_W-1:0];
        it.cross_draw = draw[DRAW_W-1:0];
        it.forced_element = forced[EL_W-1:0];
        it.cost = cost;
        return it;
    endfunction

    // Send one item beat after a random gap; track what it writes.
    task automatic send(input t_item it);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_bus.valid   <= 1'b1;
        item_bus.payload <= it;
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
        func_count[it.func]++;
        if (it.func == FUNC_LOAD && it.individual < pop_u && it.element < ind_u)
            cur_written[{it.individual, it.element}] = 1'b1;
        if (it.func == FUNC_TRIAL && trial_ok(it))
            nxt_written[{it.individual, it.element}] = 1'b1;
    endtask

    // Let every outstanding result come back, then let the block settle.
    task automatic drain();
        item_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Large populations focus on a few individuals and elements at the extremes.
    function automatic int pick_ind();
        int pool [6] = '{0, 1, 2, 3, 62, 63};
        int v;
        if (pop_u * ind_u > 512) begin
            v = pool[$urandom_range(0, 5)];
            return (v < pop_u) ? v : $urandom_range(0, pop_u - 1);
        end
        return $urandom_range(0, pop_u - 1);
    endfunction

    function automatic int pick_el();
        int pool [4] = '{0, 1, 254, 255};
        int v;
        if (pop_u * ind_u > 512) begin
            v = pool[$urandom_range(0, 3)];
            return (v < ind_u) ? v : $urandom_range(0, ind_u - 1);
        end
        return $urandom_range(0, ind_u - 1);
    endfunction

    function automatic int edge_value();
        case ($urandom_range(0, 5))
            0: return 32767;
            1: return -32768;
            2: return 0;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // One random item; unsafe reads and trials of unwritten entries turn into loads.
    function automatic t_item random_item();
        t_item it;
        int    r;
        int    ind;
        int    el;
        int    p [3];
        int    cand;
        bit    full;
        it = item_of(FUNC_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
        r = $urandom_range(0, 99);
        if (pop_u == 0 || ind_u == 0 || r < 8) begin
            // Malformed items: unknown operations, bad indices, repeated picks.
            case ($urandom_range(0, 3))
                0: it.func = FUNC_W'(FUNC_READ + $urandom_range(1, 3));
                1: begin
                    it.func = FUNC_W'($urandom_range(0, 4));
                    if (pop_u < 64) it.individual = IDX_W'($urandom_range(pop_u, 63));
                end
                2: begin
                    it.func = ($urandom_range(0, 1) != 0) ? FUNC_READ : FUNC_LOAD;
                    if (ind_u < 256) it.element = EL_W'($urandom_range(ind_u, 255));
                    else it.individual = (pop_u < 64) ? IDX_W'(63) : it.individual;
                end
                default: begin
                    it.func = FUNC_TRIAL;
                    it.pick_two = it.pick_one;
                end
            endcase
            if (it.func == FUNC_TRIAL && trial_ok(it)) it.pick_three = it.individual;
            if ((it.func == FUNC_READ || it.func == FUNC_LOAD) &&
                it.individual < pop_u && it.element < ind_u)
                it.func = FUNC_LOAD;
            if (it.func == FUNC_OFFER && it.individual < pop_u) it.cost = 32'h7FFF_FFFF;
            return it;
        end
        ind = pick_ind();
        el = pick_el();
        it.individual = IDX_W'(ind);
        it.element = EL_W'(el);
        if (r < 30) begin
            it.func = FUNC_LOAD;
            it.value = VAL_W'(edge_value());
        end else if (r < 45) begin
            it.func = FUNC_SET;
            if ($urandom_range(0, 3) == 0) it.cost = $urandom_range(0, 2) - 1;
        end else if (r < 75) begin
            it.func = FUNC_TRIAL;
            if ($urandom_range(0, 3) == 0)
                it.cross_draw = ($urandom_range(0, 1) != 0) ? '0 : 16'hFFFF;
            it.forced_element = EL_W'(($urandom_range(0, 2) == 0) ? el : pick_el());
            if (pop_u >= 4) begin
                for (int k = 0; k < 3; k++) begin
                    do cand = pick_ind();
                    while (cand == ind || (k > 0 && cand == p[0]) || (k > 1 && cand == p[1]));
                    p[k] = cand;
                end
                it.pick_one = IDX_W'(p[0]);
                it.pick_two = IDX_W'(p[1]);
                it.pick_three = IDX_W'(p[2]);
                for (int k = 0; k < 3; k++) begin
                    if (!cur_written[{p[k][IDX_W-1:0], it.element}]) begin
                        it.func = FUNC_LOAD;
                        it.individual = IDX_W'(p[k]);
                        it.value = VAL_W'(edge_value());
                    end
                end
                if (it.func == FUNC_TRIAL && !cur_written[{it.individual, it.element}]) begin
                    it.func = FUNC_LOAD;
                    it.value = VAL_W'(edge_value());
                end
            end
        end else if (r < 85) begin
            it.func = FUNC_OFFER;
            full = 1'b1;
            for (int e = 0; e < ind_u; e++)
                if (!nxt_written[{it.individual, e[EL_W-1:0]}]) full = 1'b0;
            if (!full) it.cost = 32'h7FFF_FFFF;
            else if ($urandom_range(0, 2) == 0) it.cost = 32'h8000_0000;
        end else begin
            it.func = FUNC_READ;
            if (!cur_written[{it.individual, it.element}]) begin
                it.func = FUNC_LOAD;
                it.value = VAL_W'(edge_value());
            end
        end
        return it;
    endfunction

    task automatic configure(input int pop, input int isz, input int weight, input int rate);
        write_reg(CFG_POP_SIZE, pop);
        write_reg(CFG_IND_SIZE, isz);
        write_reg(CFG_DIFF_WEIGHT, weight);
        write_reg(CFG_CROSS_RATE, rate);
        pop_u = (pop < POP_MAX) ? pop : POP_MAX;
        ind_u = (isz < IND_MAX) ? isz : IND_MAX;
    endtask

    // Stimulus: directed items at reset settings, then random phases.
    initial begin
        int ph_pop [NUM_PHASES]    = '{8, 4, 5, 16, 64, 127, 3, 0, 6};
        int ph_ind [NUM_PHASES]    = '{4, 1, 8, 16, 256, 511, 3, 0, 2};
        int ph_weight [NUM_PHASES] = '{4096, 0, 8191, -1, 8191, 1234, 2458, 7, -1};
        int ph_rate [NUM_PHASES]   = '{32768, 0, 65535, -1, 65535, 40000, 26214, 1, -1};
        int ph_items [NUM_PHASES]  = '{250, 150, 250, 300, 150, 100, 60, 30, 100};
        int total;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= '0;
        i_cfg_data         <= '0;
        item_bus.valid     <= 1'b0;
        item_bus.payload   <= '0;
        quiet              = 1'b0;
        pop_u              = POP_MAX;
        ind_u              = IND_MAX;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Saturation at both ends, keep versus mutate, extremes of indices.
        send(item_of(FUNC_LOAD, 0, 0, 32767, 0, 0, 0, 0, 0, 0));
        send(item_of(FUNC_LOAD, 1, 0, 32767, 0, 0, 0, 0, 0, 0));
        send(item_of(FUNC_LOAD, 2, 0, -32768, 0, 0, 0, 0, 0, 0));
        send(item_of(FUNC_LOAD, 3, 0, 4096, 0, 0, 0, 0, 0, 0));
        send(item_of(FUNC_LOAD, 63, 255, -32768, 63, 63, 63, 65535, 255, -1));
        send(item_of(FUNC_LOAD, 62, 255, 32767, 0, 0, 0, 0, 0, 0));
        send(item_of(FUNC_LOAD, 61, 255, -32768, 0, 0, 0, 0, 0, 0));
        send(item_of(FUNC_LOAD, 60, 255, 1, 0, 0, 0, 0, 0, 0));
        send(item_of(FUNC_TRIAL, 3, 0, 0, 2, 0, 1, 0, 0, 0));
        send(item_of(FUNC_TRIAL, 3, 0, 0, 0, 1, 2, 65535, 255, 0));
        send(item_of(FUNC_TRIAL, 60, 255, 0, 63, 61, 62, 0, 0, 0));
        send(item_of(FUNC_TRIAL, 63, 255, 0, 60, 62, 61, 65535, 255, 0));
        send(item_of(FUNC_TRIAL, 3, 0, 0, 0, 0, 1, 0, 0, 0));
        send(item_of(FUNC_TRIAL, 3, 0, 0, 3, 1, 2, 0, 0, 0));
        send(item_of(FUNC_READ, 63, 255, 0, 0, 0, 0, 0, 0, 0));
        send(item_of(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send(item_of(FUNC_SET, 5, 0, 0, 0, 0, 0, 0, 0, -100));
        send(item_of(FUNC_SET, 63, 0, 0, 0, 0, 0, 0, 0, 32'h8000_0000));
        send(item_of(FUNC_SET, 63, 0, 0, 0, 0, 0, 0, 0, 32'h8000_0000));
        send(item_of(FUNC_SET, 7, 0, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF));
        send(item_of(FUNC_OFFER, 3, 0, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF));
        send(item_of(FUNC_OFFER, 63, 0, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF));
        send(item_of(FUNC_W'(FUNC_READ + 1), 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send(item_of(3'd7, 63, 255, -1, 63, 63, 63, 65535, 255, -1));
        drain();

        // Random phases over a spread of register settings.
        total = 0;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            configure(ph_pop[ph], ph_ind[ph],
                      (ph_weight[ph] < 0) ? $urandom_range(0, 8191) : ph_weight[ph],
                      (ph_rate[ph] < 0) ? $urandom_range(0, 65535) : ph_rate[ph]);
            for (int n = 0; n < ph_items[ph]; n++) begin
                if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
                if (ph == 3 && n == ph_items[ph] / 2) drain();
                send(random_item());
                total++;
            end
            drain();
        end
        configure(POP_SIZE_RST, IND_SIZE_RST, DIFF_WEIGHT_RST, CROSS_RATE_RST);

        $display("Sent %0d random items after the directed set over %0d settings.",
                 total, NUM_PHASES);
        $display("Loads %0d, costs %0d, trials %0d, offers %0d (%0d taken), reads %0d.",
                 func_count[FUNC_LOAD], func_count[FUNC_SET], func_count[FUNC_TRIAL],
                 func_count[FUNC_OFFER], accept_count, func_count[FUNC_READ]);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
